### rtl/core/assert_macros.svh
// Assertion macros used by the RTL top level of the UART core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that is checked only while the block is out of reset.
`define ASSERT_CLKD(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Implication that is checked at every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/u8t_pkg.sv
// Package with the shared types and constants of the UART 8N1 transceiver.
`timescale 1ns / 1ps

package u8t_pkg;

    // Default frame data width.
    localparam int DATA_BITS_DEF = 8;

    // Width of the bit timing counters and of the period register.
    localparam int PERIOD_W = 16;

    // Width of the bit counters; holds counts of up to fifteen frame bits.
    localparam int CNT_W = 4;

    // Ticks per bit after reset.
    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd104;

    // Transmitter status for one tick.
    typedef struct packed {
        logic line;
        logic busy;
    } tx_status_t;

    // Receiver status for one tick.
    typedef struct packed {
        logic valid;
        logic active;
    } rx_status_t;

endpackage

### rtl/core/u8t_tx.sv
// UART transmitter: frame shift register and bit timing, one tick per step.
`timescale 1ns / 1ps

module u8t_tx
    import u8t_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                send,
    input  logic [7:0]          send_byte,
    input  logic [PERIOD_W-1:0] period,
    output tx_status_t          st
);

    localparam int FRAME_BITS = DATA_BITS + 2;

    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]      bits_left_reg, bits_left_next;
    logic [PERIOD_W-1:0]   ticks_reg, ticks_next;
    logic [DATA_BITS-1:0]  data;

    // Map the input byte onto the data bits; bits above the byte are zero.
    for (genvar j = 0; j < DATA_BITS; j++) begin : g_data
        if (j < 8) begin : g_in
            assign data[j] = send_byte[j];
        end else begin : g_zero
            assign data[j] = 1'b0;
        end
    end

    // Advance the running frame, then load a new one when idle.
    always_comb begin
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        ticks_next     = ticks_reg;
        if (bits_left_reg != '0) begin
            if (ticks_reg == '0) begin
                shift_next     = {1'b1, shift_reg[FRAME_BITS-1:1]};
                bits_left_next = bits_left_reg - CNT_W'(1);
                ticks_next     = period - PERIOD_W'(1);
            end else begin
                ticks_next = ticks_reg - PERIOD_W'(1);
            end
        end
        if (bits_left_next == '0 && send) begin
            shift_next     = {1'b1, data, 1'b0};
            bits_left_next = CNT_W'(FRAME_BITS);
            ticks_next     = period - PERIOD_W'(1);
        end
        st.busy = (bits_left_next != '0);
        st.line = st.busy ? shift_next[0] : 1'b1;
    end

    // State registers move one tick per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg     <= '1;
            bits_left_reg <= '0;
            ticks_reg     <= '0;
        end else if (step) begin
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            ticks_reg     <= ticks_next;
        end
    end

endmodule

### rtl/core/u8t_rx.sv
// UART receiver: start detection, mid-bit sampling and byte assembly.
`timescale 1ns / 1ps

module u8t_rx
    import u8t_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic                rx_line,
    input  logic [PERIOD_W-1:0] period,
    output rx_status_t          st,
    output logic [7:0]          rx_byte
);

    logic                 active_reg, active_next;
    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]     index_reg, index_next;
    logic [PERIOD_W-1:0]  ticks_reg, ticks_next;
    logic                 valid;

    // Detect a start, count to mid-bit and take one data bit per period.
    always_comb begin
        active_next = active_reg;
        shift_next  = shift_reg;
        index_next  = index_reg;
        ticks_next  = ticks_reg;
        valid       = 1'b0;
        if (!active_reg) begin
            if (!rx_line) begin
                active_next = 1'b1;
                shift_next  = '0;
                index_next  = '0;
                ticks_next  = {1'b0, period[PERIOD_W-1:1]};
            end
        end else if (ticks_reg != '0) begin
            ticks_next = ticks_reg - PERIOD_W'(1);
        end else begin
            ticks_next = period - PERIOD_W'(1);
            // The start bit sits at index zero and sets no data bit.
            for (int i = 0; i < DATA_BITS; i++) begin
                if (index_reg == CNT_W'(i + 1) && rx_line) begin
                    shift_next[i] = 1'b1;
                end
            end
            if (index_reg >= CNT_W'(DATA_BITS)) begin
                active_next = 1'b0;
                index_next  = '0;
                valid       = 1'b1;
            end else begin
                index_next = index_reg + CNT_W'(1);
            end
        end
        st.valid  = valid;
        st.active = active_next;
    end

    // Show the low byte of the assembly register; missing bits read as zero.
    for (genvar j = 0; j < 8; j++) begin : g_byte
        if (j < DATA_BITS) begin : g_bit
            assign rx_byte[j] = shift_next[j];
        end else begin : g_zero
            assign rx_byte[j] = 1'b0;
        end
    end

    // State registers move one tick per accepted item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            shift_reg  <= '0;
            index_reg  <= '0;
            ticks_reg  <= '0;
        end else if (step) begin
            active_reg <= active_next;
            shift_reg  <= shift_next;
            index_reg  <= index_next;
            ticks_reg  <= ticks_next;
        end
    end

endmodule

### rtl/core/uart_8n1_transceiver.sv
// UART 8N1 transceiver top level: tick channel, result register, period register.
//
// Each transfer on the s_ channel is one time tick: the sampled receive
// line, a send request and the byte to send. For every tick one result
// transfer leaves on the m_ channel: the transmit line level, the busy
// flag, a one-tick received-byte flag and the receive assembly byte.
// The result of a tick is in the output register on the cycle after its
// transfer. Throughput is one tick per cycle while the consumer keeps up,
// set by the single output register, which is refilled in the same cycle
// that it is drained. When the consumer holds m_ready low, the result stays put
// and s_ready drops until it is taken; no tick is lost or repeated.
// The cfg_ channel writes the bit period in ticks (zero acts as one); it
// is always ready, and a change takes effect at the next counter reload.
// Reset (aresetn low, synchronous) idles the transmit line, clears the receiver,
// empties the output register and sets the bit period to 104 ticks.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uart_8n1_transceiver
    import u8t_pkg::*;
#(
    parameter int DATA_BITS = DATA_BITS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Tick channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_rx_line,
    input  logic                s_send,
    input  logic [7:0]          s_send_byte,
    // Result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_tx_line,
    output logic                m_tx_busy,
    output logic                m_rx_valid,
    output logic [7:0]          m_rx_byte,
    // Bit period write channel
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [PERIOD_W-1:0] cfg_bit_period
);

    logic [PERIOD_W-1:0] bit_period_reg;
    logic [PERIOD_W-1:0] period_eff;
    logic                accept;
    logic                m_valid_reg, m_valid_next;
    logic                m_tx_line_reg, m_tx_busy_reg, m_rx_valid_reg;
    logic [7:0]          m_rx_byte_reg;
    tx_status_t          tx_st;
    rx_status_t          rx_st;
    logic [7:0]          rx_byte;

    // A tick is taken whenever the result register is free or being drained.
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // A zero period behaves as one tick per bit.
    assign period_eff = (bit_period_reg == '0) ? PERIOD_W'(1) : bit_period_reg;

    // Bit period register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_period_reg <= BIT_PERIOD_RST;
        end else if (cfg_valid && cfg_ready) begin
            bit_period_reg <= cfg_bit_period;
        end
    end

    u8t_tx #(
        .DATA_BITS (DATA_BITS)
    ) u_tx (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (accept),
        .send      (s_send),
        .send_byte (s_send_byte),
        .period    (period_eff),
        .st        (tx_st)
    );

    u8t_rx #(
        .DATA_BITS (DATA_BITS)
    ) u_rx (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (accept),
        .rx_line (s_rx_line),
        .period  (period_eff),
        .st      (rx_st),
        .rx_byte (rx_byte)
    );

    // Output register valid flag.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload is captured with each accepted tick.
    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tx_line_reg  <= tx_st.line;
            m_tx_busy_reg  <= tx_st.busy;
            m_rx_valid_reg <= rx_st.valid;
            m_rx_byte_reg  <= rx_byte;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_tx_line  = m_tx_line_reg;
    assign m_tx_busy  = m_tx_busy_reg;
    assign m_rx_valid = m_rx_valid_reg;
    assign m_rx_byte  = m_rx_byte_reg;

    // The transmit line idles high whenever no frame is in flight.
    `ASSERT_CLKD(a_tx_idle_high, aclk, aresetn, m_valid_reg && !m_tx_busy_reg |-> m_tx_line_reg, "tx line low while not busy")
    // A completed byte always returns the receiver to idle.
    `ASSERT_ALWAYS(a_rx_done_idle, aclk, rx_st.valid |-> !rx_st.active, "receiver still active after byte")
    // Every accepted tick produces a pending result on the next cycle.
    `ASSERT_CLKD(a_accept_result, aclk, aresetn, accept |=> m_valid_reg, "accepted tick left no result")

endmodule
